/* hdl/tcps_pkg.sv */
// shared types, widths and constants for the textured column pixel shader
package tcps_pkg;

  // default sizes
  localparam int DEF_SCREEN_HEIGHT = 1024;
  localparam int DEF_SCREEN_WIDTH  = 2048;
  localparam int DEF_TEX_MAX_DIM   = 64;
  localparam int DEF_NUM_TEXTURES  = 4;

  // field widths
  localparam int SEL_W  = 2;
  localparam int ADDR_W = 12;
  localparam int WORD_W = 32;
  localparam int X_W    = 11;
  localparam int Y_W    = 10;
  localparam int SPAN_W = 11;
  localparam int LH_W   = 20;
  localparam int COL_W  = 8;
  localparam int DIM_W  = 7;

  // texel row arithmetic: row = ((y*256 - H*128 + lh*128) * tex_h / lh) / 256
  localparam int RND_SH  = 8;
  localparam int HALF_SH = 7;
  localparam int D_W     = LH_W + HALF_SH + 1;
  localparam int N_W     = D_W + DIM_W;
  localparam int Q_W     = DIM_W;
  localparam int IDX_W   = 2 * DIM_W + 1;

  localparam logic [WORD_W-1:0] OPAQUE_BLACK = 32'h0000_00FF;

  // stream and register port widths
  localparam int IN_TDATA_W  = 120;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_PIXEL = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    REG_CEIL  = 2'd0,
    REG_WALL  = 2'd1,
    REG_FLOOR = 2'd2
  } region_t;

  typedef enum logic [1:0] {
    CFG_CEIL  = 2'd0,
    CFG_FLOOR = 2'd1,
    CFG_TEX_W = 2'd2,
    CFG_TEX_H = 2'd3
  } cfg_idx_t;

  // per-stage control and payload of one transaction
  typedef struct packed {
    req_t                req;
    logic [SEL_W-1:0]    sel;
    logic [ADDR_W-1:0]   addr;
    logic [WORD_W-1:0]   val;
    logic [X_W-1:0]      x;
    logic [Y_W-1:0]      y;
    region_t             region;
    logic                res;
    logic [COL_W-1:0]    col;
    logic [LH_W-1:0]     lh;
    logic                neg;
    logic                tex_ok;
  } stg_t;

endpackage

/* hdl/tcps_ram.sv */
// generic single write port, single read port ram with registered read
module tcps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/tcps_div.sv */
// pipelined restoring divider giving floor(num / (den*256)), one quotient bit per stage
module tcps_div (
  input  logic                     clk,
  input  logic                     en,
  input  logic [tcps_pkg::N_W-1:0]  num_i,
  input  logic [tcps_pkg::LH_W-1:0] den_i,
  output logic [tcps_pkg::Q_W-1:0]  quo_o,
  output logic                     ovf_o
);
  import tcps_pkg::*;

  localparam int OVF_SH = RND_SH + Q_W;

  logic [N_W-1:0]  rem_r  [Q_W];
  logic [LH_W-1:0] den_r  [Q_W];
  logic [Q_W-1:0]  quo_r  [Q_W+1];
  logic [Q_W:0]    ovf_r;

  logic [N_W-1:0]  trial  [Q_W];
  logic [N_W-1:0]  diff   [Q_W];
  logic [Q_W-1:0]  take;
  logic [Q_W-1:0]  bit_m  [Q_W];
  logic            ovf_c;

  // quotient must fit in Q_W bits, otherwise the row is out of any texture
  assign ovf_c = num_i >= (N_W'(den_i) << OVF_SH);

  always_comb begin
    for (int k = 0; k < Q_W; k++) begin
      trial[k] = N_W'(den_r[k]) << (RND_SH + Q_W - 1 - k);
      take[k]  = rem_r[k] >= trial[k];
      diff[k]  = rem_r[k] - trial[k];
      bit_m[k] = Q_W'(1) << (Q_W - 1 - k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_i;
      den_r[0] <= den_i;
      quo_r[0] <= '0;
      ovf_r    <= {ovf_r[Q_W-1:0], ovf_c};
      for (int k = 0; k < Q_W; k++) begin
        quo_r[k+1] <= take[k] ? (quo_r[k] | bit_m[k]) : quo_r[k];
      end
      for (int k = 1; k < Q_W; k++) begin
        rem_r[k] <= take[k-1] ? diff[k-1] : rem_r[k-1];
        den_r[k] <= den_r[k-1];
      end
    end
  end

  assign quo_o = quo_r[Q_W];
  assign ovf_o = ovf_r[Q_W];

endmodule

/* hdl/textured_column_pixel_shader_unit.sv */
// top level of the textured column pixel shader: stage pipeline, divider and texture store
//
//  channel | dir | handshake               | payload
//  in_     | in  | in_tvalid / in_tready   | in_tdata fields, in_tuser kind and texture
//  out_    | out | out_tvalid / out_tready | out_tdata pixel, out_tuser region
//  cfg_    | in  | apb read/write, pready high | four registers at 0x0, 0x4, 0x8, 0xc
//
// one transaction per clock while in_tready is high; a shaded pixel is registered through every stage before out_tvalid
// latency is set by the multiply, the divider and the texture store read
// loads write the store at the same stage where pixels read it, so order is kept as given
// in_tready drops only while a result sits at the last stage and the output register is held
// synchronous reset clears valids and colour registers and sets texture sizes to TEX_MAX_DIM; the store is not cleared
module textured_column_pixel_shader_unit #(
  parameter int SCREEN_HEIGHT = tcps_pkg::DEF_SCREEN_HEIGHT,
  parameter int SCREEN_WIDTH  = tcps_pkg::DEF_SCREEN_WIDTH,
  parameter int TEX_MAX_DIM   = tcps_pkg::DEF_TEX_MAX_DIM,
  parameter int NUM_TEXTURES  = tcps_pkg::DEF_NUM_TEXTURES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // texel_addr, texel_value, column_x, pixel_y, span_start, span_end, wall_rows, tex_column
  input  logic [tcps_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type, tex_select
  input  logic [tcps_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_x, out_y, pixel_color
  output logic [tcps_pkg::OUT_TDATA_W-1:0] out_tdata,
  // region
  output logic [tcps_pkg::OUT_TUSER_W-1:0] out_tuser,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [tcps_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [tcps_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [tcps_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import tcps_pkg::*;

  localparam int TEX_WORDS = TEX_MAX_DIM * TEX_MAX_DIM;
  localparam int MEM_DEPTH = NUM_TEXTURES * TEX_WORDS;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int H_OFF     = SCREEN_HEIGHT << HALF_SH;
  localparam int S_MUL     = 1;
  localparam int S_IDX     = S_MUL + Q_W + 2;
  localparam int S_MEM     = S_IDX + 1;
  localparam int NSTG      = S_MEM + 1;

  // input tdata layout
  localparam int I_ADDR  = 0;
  localparam int I_VAL   = I_ADDR + ADDR_W;
  localparam int I_X     = I_VAL + WORD_W;
  localparam int I_Y     = I_X + X_W;
  localparam int I_START = I_Y + Y_W;
  localparam int I_END   = I_START + SPAN_W;
  localparam int I_LH    = I_END + SPAN_W;
  localparam int I_COL   = I_LH + LH_W;
  localparam int OUT_PAD = OUT_TDATA_W - X_W - Y_W - WORD_W;

  // configuration registers
  logic [WORD_W-1:0] ceil_col_r;
  logic [WORD_W-1:0] floor_col_r;
  logic [DIM_W-1:0]  tex_w_r;
  logic [DIM_W-1:0]  tex_h_r;
  logic              cfg_wr;
  cfg_idx_t          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_col_r  <= '0;
      floor_col_r <= '0;
      tex_w_r     <= DIM_W'(TEX_MAX_DIM);
      tex_h_r     <= DIM_W'(TEX_MAX_DIM);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_CEIL:  ceil_col_r  <= cfg_pwdata[WORD_W-1:0];
        CFG_FLOOR: floor_col_r <= cfg_pwdata[WORD_W-1:0];
        CFG_TEX_W: tex_w_r     <= cfg_pwdata[DIM_W-1:0];
        CFG_TEX_H: tex_h_r     <= cfg_pwdata[DIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_CEIL:  cfg_prdata = ceil_col_r;
      CFG_FLOOR: cfg_prdata = floor_col_r;
      CFG_TEX_W: cfg_prdata = CFG_DATA_W'(tex_w_r);
      CFG_TEX_H: cfg_prdata = CFG_DATA_W'(tex_h_r);
    endcase
  end

  // pipeline control
  logic [NSTG-1:0] vld_r;
  stg_t            ctl_r [NSTG];
  logic            adv;
  logic            out_valid_r;

  assign adv       = !(vld_r[S_MEM] && ctl_r[S_MEM].res && out_valid_r && !out_tready);
  assign in_tready = adv;

  // stage 0 decode
  logic [Y_W-1:0]    f_y;
  logic [X_W-1:0]    f_x;
  logic [SPAN_W-1:0] f_start;
  logic [SPAN_W-1:0] f_end;
  logic [LH_W-1:0]   f_lh;
  logic [D_W-1:0]    f_pos;
  logic              f_neg;
  logic [D_W-1:0]    f_absd;
  stg_t              ctl_in;
  logic [D_W-1:0]    absd_r;
  logic [N_W-1:0]    n_r;

  assign f_y     = in_tdata[I_Y +: Y_W];
  assign f_x     = in_tdata[I_X +: X_W];
  assign f_start = in_tdata[I_START +: SPAN_W];
  assign f_end   = in_tdata[I_END +: SPAN_W];
  assign f_lh    = in_tdata[I_LH +: LH_W];

  // signed offset y*256 - H*128 + lh*128 kept as magnitude and sign
  assign f_pos  = (D_W'(f_y) << RND_SH) + (D_W'(f_lh) << HALF_SH);
  assign f_neg  = f_pos < D_W'(H_OFF);
  assign f_absd = f_neg ? (D_W'(H_OFF) - f_pos) : (f_pos - D_W'(H_OFF));

  always_comb begin
    ctl_in        = '0;
    ctl_in.req    = req_t'(in_tuser[0]);
    ctl_in.sel    = in_tuser[1 +: SEL_W];
    ctl_in.addr   = in_tdata[I_ADDR +: ADDR_W];
    ctl_in.val    = in_tdata[I_VAL +: WORD_W];
    ctl_in.x      = f_x;
    ctl_in.y      = f_y;
    ctl_in.col    = in_tdata[I_COL +: COL_W];
    ctl_in.lh     = f_lh;
    ctl_in.neg    = f_neg;
    ctl_in.tex_ok = 1'b0;
    ctl_in.res    = (ctl_in.req == REQ_PIXEL) && (int'(f_y) < SCREEN_HEIGHT)
                    && (int'(f_x) < SCREEN_WIDTH);
    // floor wins over ceiling and wall
    priority if ({1'b0, f_y} >= f_end) begin
      ctl_in.region = REG_FLOOR;
    end else if ({1'b0, f_y} < f_start) begin
      ctl_in.region = REG_CEIL;
    end else begin
      ctl_in.region = REG_WALL;
    end
  end

  // divider
  logic [Q_W-1:0] div_q;
  logic           div_ovf;

  tcps_div u_div (
    .clk   (clk),
    .en    (adv),
    .num_i (n_r),
    .den_i (ctl_r[S_MUL].lh),
    .quo_o (div_q),
    .ovf_o (div_ovf)
  );

  // texel address stage
  stg_t              c_div;
  logic              sel_ok;
  logic              col_ok;
  logic              row_ok;
  logic [IDX_W-1:0]  idx;
  logic              tex_ok_c;
  stg_t              c_idx;
  logic [MEM_AW-1:0] mem_addr_c;
  logic              mem_we_c;
  logic              mem_re_c;
  logic [MEM_AW-1:0] mem_addr_r;
  logic              mem_we_r;
  logic              mem_re_r;

  assign c_div  = ctl_r[S_IDX-1];
  assign sel_ok = int'(c_div.sel) < NUM_TEXTURES;
  assign col_ok = !c_div.col[COL_W-1] && (c_div.col[COL_W-2:0] < tex_w_r);
  // a negative row survives only when it truncates to zero
  assign row_ok = !div_ovf && (!c_div.neg || (div_q == '0)) && (div_q < tex_h_r);
  assign idx    = (IDX_W'(div_q) * IDX_W'(tex_w_r)) + IDX_W'(c_div.col[COL_W-2:0]);

  assign tex_ok_c   = sel_ok && col_ok && row_ok && (int'(idx) < TEX_WORDS);
  assign mem_we_c   = (c_div.req == REQ_LOAD) && sel_ok && (int'(c_div.addr) < TEX_WORDS);
  assign mem_re_c   = (c_div.req == REQ_PIXEL) && c_div.res && (c_div.region == REG_WALL)
                      && tex_ok_c;
  assign mem_addr_c = MEM_AW'(int'(c_div.sel) * TEX_WORDS
                      + ((c_div.req == REQ_LOAD) ? int'(c_div.addr) : int'(idx)));

  always_comb begin
    c_idx        = c_div;
    c_idx.tex_ok = tex_ok_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r[0] <= ctl_in;
      for (int k = 1; k < NSTG; k++) begin
        if (k == S_IDX) begin
          ctl_r[k] <= c_idx;
        end else begin
          ctl_r[k] <= ctl_r[k-1];
        end
      end
      absd_r     <= f_absd;
      n_r        <= N_W'(absd_r) * N_W'(tex_h_r);
      mem_addr_r <= mem_addr_c;
      mem_we_r   <= mem_we_c;
      mem_re_r   <= mem_re_c;
    end
  end

  // texture store
  logic [WORD_W-1:0] rd_data;

  tcps_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_DEPTH)
  ) u_tex_ram (
    .clk   (clk),
    .we    (adv && vld_r[S_IDX] && mem_we_r),
    .waddr (mem_addr_r),
    .wdata (ctl_r[S_IDX].val),
    .re    (adv && vld_r[S_IDX] && mem_re_r),
    .raddr (mem_addr_r),
    .rdata (rd_data)
  );

  // output register
  stg_t              c_mem;
  logic [WORD_W-1:0] color_c;
  logic              out_valid_nxt;
  logic [X_W-1:0]    out_x_r;
  logic [Y_W-1:0]    out_y_r;
  logic [WORD_W-1:0] out_col_r;
  region_t           out_reg_r;

  assign c_mem = ctl_r[S_MEM];

  always_comb begin
    unique case (c_mem.region)
      REG_CEIL:  color_c = ceil_col_r;
      REG_FLOOR: color_c = floor_col_r;
      REG_WALL:  color_c = c_mem.tex_ok ? rd_data : OPAQUE_BLACK;
      default:   color_c = OPAQUE_BLACK;
    endcase
  end

  always_comb begin
    priority if (adv && vld_r[S_MEM] && c_mem.res) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld_r[S_MEM] && c_mem.res) begin
      out_x_r   <= c_mem.x;
      out_y_r   <= c_mem.y;
      out_col_r <= color_c;
      out_reg_r <= c_mem.region;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_col_r, out_y_r, out_x_r};
  assign out_tuser  = out_reg_r;

endmodule

/* hdl/tcps_chk.sv */
// port-level checks for the textured column pixel shader, bound to the top level
module tcps_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tcps_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [tcps_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import tcps_pkg::*;

  // a held result keeps its transaction intact
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output transaction changed while stalled");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // the input only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output back-pressure");

endmodule

bind textured_column_pixel_shader_unit tcps_chk u_tcps_chk (.*);
